// ===== rtl/ncs_pkg.sv =====
// Shared constants and the field-to-coefficient mapping of the noise coefficient sampler.
package ncs_pkg;

  localparam int unsigned CoeffsPerPolyDefault = 256;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned CoefW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CarryW = 6;
  localparam int unsigned CntW   = 3;
  localparam int unsigned AccW   = 12;

  localparam logic [ModeW-1:0] MODE_FOUR  = 2'd0;
  localparam logic [ModeW-1:0] MODE_SIX   = 2'd1;
  localparam logic [ModeW-1:0] MODE_EIGHT = 2'd2;

  localparam logic [CntW-1:0] CNT_MAX = 3'd4;

  // low_ones: every bit below the top is 1; a1: lowest bit; top: highest bit
  function automatic logic signed [CoefW-1:0] sample_coef(input logic low_ones,
                                                          input logic a1,
                                                          input logic top);
    logic [CoefW-1:0] mag;
    if (low_ones) begin
      mag = 3'd2;
    end else if (a1) begin
      mag = 3'd0;
    end else begin
      mag = 3'd1;
    end
    if (top) begin
      return $signed(mag);
    end
    return $signed(3'(3'd0 - mag));
  endfunction

endpackage

// ===== rtl/noise_coefficient_sampler.sv =====
// Noise coefficient sampler: noise bytes in, coefficients in -2..2 out.
//
// Bytes are read as a little-endian bit stream and cut into 4-, 6- or 8-bit fields
// (field_mode at addresses 0 to 3: 0, 1, 2; 3 acts as 2). Each field gives one
// coefficient, and last_coefficient marks every COEFFS_PER_POLY-th one. A byte gives
// a single coefficient (8-bit mode, 6-bit mode with 0 or 2 bits carried) or two (4-bit
// mode, 6-bit mode with 4 bits carried); as the result port carries one coefficient
// per transfer, the second coefficient waits in a hold register. The first coefficient
// of a byte is offered the cycle after its transfer. The input stalls while a
// coefficient is held back, and a byte is taken in the cycle the last waiting
// coefficient leaves. Write field_mode only while idle; a change keeps the carried
// bits and the coefficient counter, and a byte in 4- or 8-bit mode drops carried
// bits. No start-up delay after reset.
module noise_coefficient_sampler #(
  parameter int unsigned COEFFS_PER_POLY = ncs_pkg::CoeffsPerPolyDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ncs_pkg::ByteW-1:0]        noise_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ncs_pkg::CoefW-1:0] coefficient_o,
  output logic                             last_coefficient_o
);

  localparam int unsigned IdxW = (COEFFS_PER_POLY > 1) ? $clog2(COEFFS_PER_POLY) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(COEFFS_PER_POLY - 1);

  logic [ncs_pkg::ModeW-1:0]  mode_q;
  logic [ncs_pkg::CarryW-1:0] carry_q, carry_d;
  logic [ncs_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]            idx_q, idx_d;

  logic                             o_valid_q, o_last_q;
  logic signed [ncs_pkg::CoefW-1:0] o_coef_q;
  logic                             h_valid_q, h_last_q;
  logic signed [ncs_pkg::CoefW-1:0] h_coef_q;

  logic cfg_wr, in_xfer, out_xfer, out_free;

  logic [ncs_pkg::CntW-1:0] cnt_eff;
  logic [ncs_pkg::AccW-1:0] acc, acc_mask;
  logic [3:0]               total;
  logic                     six_two;

  logic                             two;
  logic signed [ncs_pkg::CoefW-1:0] coef0, coef1;
  logic                             last0, last1;
  logic [IdxW-1:0]                  idx_b;

  // configuration
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = {30'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ncs_pkg::MODE_FOUR;
    end else if (cfg_wr && !paddr[2]) begin
      mode_q <= pwdata[ncs_pkg::ModeW-1:0];
    end
  end

  // handshakes
  assign out_xfer   = o_valid_q && !out_stall_i;
  assign out_free   = !o_valid_q || out_xfer;
  assign in_stall_o = h_valid_q || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // 6-bit carry path
  always_comb begin
    cnt_eff  = (cnt_q > ncs_pkg::CNT_MAX) ? ncs_pkg::CNT_MAX : cnt_q;
    acc_mask = 12'((12'd1 << cnt_eff) - 12'd1);
    acc      = (12'(noise_byte_i) << cnt_eff) | (12'(carry_q) & acc_mask);
    total    = 4'(cnt_eff) + 4'd8;
    six_two  = (total >= 4'd12);
  end

  // field sampling
  always_comb begin
    two     = 1'b0;
    coef0   = '0;
    coef1   = '0;
    carry_d = '0;
    cnt_d   = '0;
    case (mode_q)
      ncs_pkg::MODE_FOUR: begin
        two   = 1'b1;
        coef0 = ncs_pkg::sample_coef(&noise_byte_i[2:0], noise_byte_i[0], noise_byte_i[3]);
        coef1 = ncs_pkg::sample_coef(&noise_byte_i[6:4], noise_byte_i[4], noise_byte_i[7]);
      end
      ncs_pkg::MODE_SIX: begin
        two   = six_two;
        coef0 = ncs_pkg::sample_coef(&acc[4:0], acc[0], acc[5]);
        coef1 = ncs_pkg::sample_coef(&acc[10:6], acc[6], acc[11]);
        if (six_two) begin
          carry_d = '0;
          cnt_d   = 3'(total - 4'd12);
        end else begin
          carry_d = acc[11:6];
          cnt_d   = 3'(total - 4'd6);
        end
      end
      default: begin
        coef0 = ncs_pkg::sample_coef(&noise_byte_i[6:0], noise_byte_i[0], noise_byte_i[7]);
      end
    endcase
  end

  // coefficient position
  always_comb begin
    last0 = (idx_q == IdxLast);
    idx_b = last0 ? '0 : IdxW'(idx_q + 1'b1);
    last1 = (idx_b == IdxLast);
    if (two) begin
      idx_d = last1 ? '0 : IdxW'(idx_b + 1'b1);
    end else begin
      idx_d = idx_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (in_xfer) begin
      carry_q <= carry_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // output and hold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
    end else begin
      if (h_valid_q) begin
        if (out_free) begin
          o_valid_q <= 1'b1;
          h_valid_q <= 1'b0;
        end
      end else if (in_xfer) begin
        o_valid_q <= 1'b1;
        h_valid_q <= two;
      end else if (out_xfer) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_valid_q) begin
      if (out_free) begin
        o_coef_q <= h_coef_q;
        o_last_q <= h_last_q;
      end
    end else if (in_xfer) begin
      o_coef_q <= coef0;
      o_last_q <= last0;
      h_coef_q <= coef1;
      h_last_q <= last1;
    end
  end

  assign out_valid_o        = o_valid_q;
  assign coefficient_o      = o_coef_q;
  assign last_coefficient_o = o_last_q;

  a_hold_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid_q |-> o_valid_q)
    else $error("hold register full while output register empty");

  a_xfer_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> o_valid_q)
    else $error("accepted byte left no result");

  a_carry_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd0) || (cnt_q == 3'd2) || (cnt_q == 3'd4))
    else $error("carried bit count out of range");

  a_aligned_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (mode_q != ncs_pkg::MODE_SIX)) |=> (cnt_q == 3'd0))
    else $error("carried bits kept in byte-aligned mode");

  a_hold_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_valid_q && out_free) |=> !h_valid_q)
    else $error("hold register did not drain");

endmodule
